@@ rtl/depth_bucket_binner_macros.svh @@
// Assertion macros for the depth bucket binner.
`ifndef DEPTH_BUCKET_BINNER_MACROS_SVH
`define DEPTH_BUCKET_BINNER_MACROS_SVH

`ifndef ASSERT_OFF
`define DBB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("depth_bucket_binner: check failed");
`define DBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("depth_bucket_binner: check failed");
`else
`define DBB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DBB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/dbb_pkg.sv @@
// Types and constants for the depth bucket binner.
package dbb_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int OFS_W      = 24;
    localparam int DEPTH_W    = 23;
    localparam int IDX_W      = 11;
    localparam int OUT_IDX_W  = 10;
    localparam int IOFS_W     = 11;
    localparam int DIV_STEPS  = 13;

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DEPTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DEPTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKETS      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_DEPTH,
        S_DEN,
        S_MUL,
        S_DLOAD,
        S_DIV,
        S_FIN
    } state_t;

endpackage

@@ rtl/depth_bucket_binner.sv @@
// Depth bucket binner: length, depth, bucket division and frame span tracking.
//
// channel  direction  handshake            payload
// s_       in         s_valid / s_ready    mode, pos_x, pos_y, pos_z, index_offset
// m_       out        m_valid / m_ready    bucket_index, lowest/highest_touched, range_valid
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A bin beat (AW = max(COORD_WIDTH, 23)) runs three squares on the shared multiplier,
// AW+1 root steps and 13 divide steps on the shared subtractor. A negative depth
// skips the multiply and divide, and an end-frame beat goes straight to S_FIN.
// s_ready is high only while the sequencer is idle; a result held by m_ready stalls it.
// Reset is synchronous on aresetn low; cfg_ready is always high.
`include "depth_bucket_binner_macros.svh"

module depth_bucket_binner #(
    parameter int NUM_BUCKETS = 1024,
    parameter int COORD_WIDTH = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dbb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dbb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic signed [COORD_WIDTH-1:0]       s_pos_x,
    input  logic signed [COORD_WIDTH-1:0]       s_pos_y,
    input  logic signed [COORD_WIDTH-1:0]       s_pos_z,
    input  logic signed [dbb_pkg::IOFS_W-1:0]   s_index_offset,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dbb_pkg::OUT_IDX_W-1:0]       m_bucket_index,
    output logic [dbb_pkg::OUT_IDX_W-1:0]       m_lowest_touched,
    output logic [dbb_pkg::OUT_IDX_W-1:0]       m_highest_touched,
    output logic                                m_range_valid
);
    import dbb_pkg::*;

    localparam int AW     = (COORD_WIDTH > DEPTH_W) ? COORD_WIDTH : DEPTH_W;
    localparam int MW     = AW + 2;
    localparam int SW     = 2 * MW;
    localparam int SQW    = 2 * AW + 2;
    localparam int DW     = AW + 3;
    localparam int CNT_W  = $clog2(AW + 2);
    localparam int NB_MAX = (1 << IDX_W) - 1;
    localparam int NB_CAP = (NUM_BUCKETS > NB_MAX) ? NB_MAX : NUM_BUCKETS;
    localparam int RST_N  = (NB_CAP < 1024) ? NB_CAP : 1024;
    localparam int OUT_SPAN = 1 << OUT_IDX_W;

    localparam logic [IDX_W-1:0] NB_CAP_W  = IDX_W'(NB_CAP);
    localparam logic [IDX_W-1:0] LO_RST    = IDX_W'((RST_N - 1) % OUT_SPAN);
    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(AW);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic signed [OFS_W-1:0] ofs_reg;
    logic [DEPTH_W-1:0]      mind_reg;
    logic [DEPTH_W-1:0]      maxd_reg;
    logic [IDX_W-1:0]        biu_reg;

    logic                     mode_reg;
    logic [AW-1:0]            ax_reg, ay_reg, az_reg;
    logic signed [IOFS_W-1:0] ioff_reg;
    logic [SW-1:0]            prod_reg;
    logic [SQW-1:0]           acc_reg;
    logic [SW-1:0]            rem_reg;
    logic [AW:0]              root_reg;
    logic [SW-1:0]            dvs_reg;
    logic [DIV_STEPS-1:0]     quo_reg;
    logic signed [DW-1:0]     depth_reg;
    logic signed [DW:0]       den_reg;
    logic                     neg_reg;

    logic [IDX_W-1:0] lo_reg, hi_reg;
    logic             m_valid_reg;
    logic [OUT_IDX_W-1:0] bucket_out_reg, lo_out_reg, hi_out_reg;
    logic             range_out_reg;

    logic [IDX_W-1:0] n_eff, n_m1, clr_lo;
    logic signed [AW+1:0] xe, ye, ze, abs_x, abs_y, neg_z, md_e, clamp_z;
    logic [MW-1:0] mul_a, mul_b;
    logic [SW-1:0] mul_p;
    logic [SW-1:0] sub_a, sub_b;
    logic [SW:0]   sub_d;
    logic          sub_ge;
    logic signed [DW-1:0] depth_next;
    logic signed [DW:0]   den_next;
    logic signed [IDX_W+3:0] idx_sum;
    logic [IDX_W-1:0] bucket, new_lo, new_hi, rep_lo, rep_hi;
    logic          fin_go, den_le0;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_reg  <= '0;
            mind_reg <= DEPTH_W'(256);
            maxd_reg <= {DEPTH_W{1'b1}};
            biu_reg  <= IDX_W'(1024);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DEPTH_OFFSET: ofs_reg  <= cfg_data[OFS_W-1:0];
                REG_MIN_DEPTH:    mind_reg <= cfg_data[DEPTH_W-1:0];
                REG_MAX_DEPTH:    maxd_reg <= cfg_data[DEPTH_W-1:0];
                REG_BUCKETS:      biu_reg  <= cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (biu_reg == '0) begin
            n_eff = IDX_W'(1);
        end else if (biu_reg > NB_CAP_W) begin
            n_eff = NB_CAP_W;
        end else begin
            n_eff = biu_reg;
        end
    end
    assign n_m1   = n_eff - 1'b1;
    assign clr_lo = {{(IDX_W-OUT_IDX_W){1'b0}}, n_m1[OUT_IDX_W-1:0]};

    assign xe      = {{(AW+2-COORD_WIDTH){s_pos_x[COORD_WIDTH-1]}}, s_pos_x};
    assign ye      = {{(AW+2-COORD_WIDTH){s_pos_y[COORD_WIDTH-1]}}, s_pos_y};
    assign ze      = {{(AW+2-COORD_WIDTH){s_pos_z[COORD_WIDTH-1]}}, s_pos_z};
    assign abs_x   = xe[AW+1] ? -xe : xe;
    assign abs_y   = ye[AW+1] ? -ye : ye;
    assign neg_z   = -ze;
    assign md_e    = {{(AW+2-DEPTH_W){1'b0}}, mind_reg};
    assign clamp_z = (neg_z < md_e) ? md_e : neg_z;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ: begin
                if (cnt_reg == CNT_W'(0)) begin
                    mul_a = {2'b00, ax_reg};
                end else if (cnt_reg == CNT_W'(1)) begin
                    mul_a = {2'b00, ay_reg};
                end else begin
                    mul_a = {2'b00, az_reg};
                end
                mul_b = mul_a;
            end
            S_MUL: begin
                mul_a = depth_reg[MW-1:0];
                mul_b = {{(MW-IDX_W){1'b0}}, n_eff};
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        sub_a = '0;
        sub_b = '0;
        case (state_reg)
            S_ROOT: begin
                sub_a = {rem_reg[SW-3:0], acc_reg[SQW-1 -: 2]};
                sub_b = {{(SW-AW-3){1'b0}}, root_reg, 2'b01};
            end
            S_DIV: begin
                sub_a = rem_reg;
                sub_b = dvs_reg;
            end
            default: ;
        endcase
    end
    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = !sub_d[SW];

    assign depth_next = $signed({2'b00, root_reg})
                      + $signed({{(DW-OFS_W){ofs_reg[OFS_W-1]}}, ofs_reg})
                      - $signed({{(DW-DEPTH_W){1'b0}}, mind_reg});
    assign den_next   = $signed({depth_reg[DW-1], depth_reg})
                      + $signed({{(DW+1-DEPTH_W){1'b0}}, maxd_reg})
                      - $signed({{(DW+1-DEPTH_W){1'b0}}, mind_reg});
    assign den_le0    = den_reg[DW] || (den_reg == '0);

    assign idx_sum = $signed({2'b00, quo_reg})
                   + $signed({{(IDX_W+4-IOFS_W){ioff_reg[IOFS_W-1]}}, ioff_reg});

    always_comb begin
        if (neg_reg || mode_reg) begin
            bucket = '0;
        end else if (idx_sum[IDX_W+3]) begin
            bucket = '0;
        end else if (idx_sum >= $signed({4'b0000, n_eff})) begin
            bucket = n_m1;
        end else begin
            bucket = idx_sum[IDX_W-1:0];
        end
    end
    assign new_lo = (bucket < lo_reg) ? bucket : lo_reg;
    assign new_hi = (bucket > hi_reg) ? bucket : hi_reg;
    assign rep_lo = mode_reg ? lo_reg : new_lo;
    assign rep_hi = mode_reg ? hi_reg : new_hi;
    assign fin_go = (state_reg == S_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = s_mode ? S_FIN : S_SQ;
                end
            end
            S_SQ: begin
                if (cnt_reg == SQ_LAST) begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT: begin
                if (cnt_reg == ROOT_LAST) begin
                    state_next = S_DEPTH;
                end
            end
            S_DEPTH: state_next = S_DEN;
            S_DEN:   state_next = depth_reg[DW-1] ? S_FIN : S_MUL;
            S_MUL:   state_next = den_le0 ? S_FIN : S_DLOAD;
            S_DLOAD: state_next = S_DIV;
            S_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign cnt_next = (state_next != state_reg) ? '0 : cnt_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            lo_reg      <= LO_RST;
            hi_reg      <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (fin_go) begin
                m_valid_reg <= 1'b1;
                if (mode_reg) begin
                    lo_reg <= clr_lo;
                    hi_reg <= '0;
                end else begin
                    lo_reg <= new_lo;
                    hi_reg <= new_hi;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                mode_reg <= s_mode;
                ax_reg   <= abs_x[AW-1:0];
                ay_reg   <= abs_y[AW-1:0];
                az_reg   <= clamp_z[AW-1:0];
                ioff_reg <= s_index_offset;
                neg_reg  <= 1'b0;
            end
            S_SQ: begin
                prod_reg <= mul_p;
                acc_reg  <= (cnt_reg == CNT_W'(0)) ? '0 : acc_reg + prod_reg[SQW-1:0];
                rem_reg  <= '0;
                root_reg <= '0;
            end
            S_ROOT: begin
                acc_reg <= acc_reg << 2;
                if (sub_ge) begin
                    rem_reg  <= sub_d[SW-1:0];
                    root_reg <= {root_reg[AW-1:0], 1'b1};
                end else begin
                    rem_reg  <= sub_a;
                    root_reg <= {root_reg[AW-1:0], 1'b0};
                end
            end
            S_DEPTH: depth_reg <= depth_next;
            S_DEN: begin
                den_reg <= den_next;
                neg_reg <= depth_reg[DW-1];
            end
            S_MUL: begin
                prod_reg <= mul_p;
                dvs_reg  <= SW'(den_reg[DW-1:0]) << (DIV_STEPS - 1);
                quo_reg  <= '0;
            end
            S_DLOAD: rem_reg <= prod_reg;
            S_DIV: begin
                dvs_reg <= dvs_reg >> 1;
                quo_reg <= {quo_reg[DIV_STEPS-2:0], sub_ge};
                if (sub_ge) begin
                    rem_reg <= sub_d[SW-1:0];
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    bucket_out_reg <= bucket[OUT_IDX_W-1:0];
                    lo_out_reg     <= rep_lo[OUT_IDX_W-1:0];
                    hi_out_reg     <= rep_hi[OUT_IDX_W-1:0];
                    range_out_reg  <= (rep_hi >= rep_lo);
                end
            end
            default: ;
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_bucket_index    = bucket_out_reg;
    assign m_lowest_touched  = lo_out_reg;
    assign m_highest_touched = hi_out_reg;
    assign m_range_valid     = range_out_reg;

    `DBB_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready, state_reg != S_IDLE)
    `DBB_ASSERT_SAME(a_div_bound, aclk, aresetn, state_reg == S_DIV, cnt_reg <= DIV_LAST)
    `DBB_ASSERT_NEXT(a_fin_loads, aclk, aresetn, fin_go, m_valid_reg && (state_reg == S_IDLE))

endmodule
